// File: src/iir_tdf2_pkg.sv
// Shared types and constants for the transposed direct form II IIR filter.
package iir_tdf2_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int CHANNEL_W  = 2;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_IDX_W = 4;
	localparam int COEF_W     = 24;
	localparam int GAIN_W     = 16;

	// y and z are Q10.30
	localparam int Z_W     = 40;
	localparam int YLO_W   = 20;
	localparam int MUL_B_W = YLO_W + 1;
	localparam int PROD_W  = COEF_W + MUL_B_W;
	localparam int ACC_W   = 46;
	localparam int GACC_W  = 58;

	localparam logic signed [COEF_W-1:0]   COEF_ONE   = 24'sh100000;
	localparam logic [GAIN_W-1:0]          GAIN_RESET = 16'd4096;
	localparam logic signed [Z_W-1:0]      Z_MAX      = 40'sh7F_FFFF_FFFF;
	localparam logic signed [Z_W-1:0]      Z_MIN      = 40'sh80_0000_0000;
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX    = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN    = 16'sh8000;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_NUM    = 2'd1,
		REQ_DEN    = 2'd2
	} req_type_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_BX,
		ST_ALO,
		ST_AHI,
		ST_WB,
		ST_G1,
		ST_G2,
		ST_G3
	} state_t;

	// saturate an accumulator value to the signed 40-bit range of y and z
	function automatic logic signed [Z_W-1:0] sat_z(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-Z_W:0] hi;
		hi = v[ACC_W-1:Z_W-1];
		if ((&hi) || (~|hi))
			sat_z = v[Z_W-1:0];
		else if (v[ACC_W-1])
			sat_z = Z_MIN;
		else
			sat_z = Z_MAX;
	endfunction

endpackage

// File: src/iir_req_if.sv
// Request channel: samples and coefficient writes.
interface iir_req_if;
	logic                                      valid;
	logic                                      ready;
	logic [iir_tdf2_pkg::REQ_TYPE_W-1:0]       req_type;
	logic [iir_tdf2_pkg::CHANNEL_W-1:0]        channel;
	logic signed [iir_tdf2_pkg::SAMPLE_W-1:0]  sample_in;
	logic [iir_tdf2_pkg::COEF_IDX_W-1:0]       coef_index;
	logic signed [iir_tdf2_pkg::COEF_W-1:0]    coef_value;

	modport source (
		output valid, req_type, channel, sample_in, coef_index, coef_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, channel, sample_in, coef_index, coef_value,
		output ready
	);
endinterface

// File: src/iir_rsp_if.sv
// Response channel: filtered samples.
interface iir_rsp_if;
	logic                                      valid;
	logic                                      ready;
	logic [iir_tdf2_pkg::CHANNEL_W-1:0]        channel_out;
	logic signed [iir_tdf2_pkg::SAMPLE_W-1:0]  sample_out;
	logic                                      saturated;

	modport source (
		output valid, channel_out, sample_out, saturated,
		input  ready
	);
	modport sink (
		input  valid, channel_out, sample_out, saturated,
		output ready
	);
endinterface

// File: src/iir_filter_transposed_df2.sv
// Multi-channel transposed direct form II IIR filter around one shared multiplier.
//
// Channel  | Direction | Handshake        | Carries
// ---------+-----------+------------------+--------------------------------------------
// req      | in        | valid/ready      | sample or numerator/denominator coefficient
// rsp      | out       | valid/ready      | channel, gained and saturated sample
// cfg      | in        | cfg_wr_en        | output gain, Q4.12
//
// A sample transaction occupies the block from ST_FETCH through ST_G3, with req.ready low:
// the 24x21 multiplier is used three times per tap (b*x and both halves of a*y), plus
// y and two gain products. The next request is taken only once the block is back in ST_IDLE.
// Coefficient transactions leave the block in ST_IDLE, ready for the next request. After
// reset a clear sweep of the delay lines and coefficient memories holds req.ready low.
// The result register lets the next sample start; only the final step waits on rsp.ready.
module iir_filter_transposed_df2 #(
	parameter int FILTER_ORDER = 8,
	parameter int CHANNELS     = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [iir_tdf2_pkg::GAIN_W-1:0]   cfg_wr_data,
	iir_req_if.sink                           req,
	iir_rsp_if.source                         rsp
);
	import iir_tdf2_pkg::*;

	localparam int NUM_N  = FILTER_ORDER + 1;
	localparam int NUM_AW = $clog2(NUM_N);
	localparam int DEN_AW = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
	localparam int DL_N   = CHANNELS * FILTER_ORDER;
	localparam int DL_AW  = (DL_N > 1) ? $clog2(DL_N) : 1;
	localparam int CLR_N  = (DL_N > NUM_N) ? DL_N : NUM_N;
	localparam int CLR_W  = $clog2(CLR_N);
	localparam int TAP_W  = NUM_AW + 1;

	localparam logic signed [PROD_W-1:0] RND5  = PROD_W'(16);
	localparam logic signed [PROD_W-1:0] RND20 = PROD_W'(524288);
	localparam logic signed [GACC_W-1:0] RND27 = GACC_W'(67108864);

	// storage
	logic signed [COEF_W-1:0] num_mem [NUM_N];
	logic signed [COEF_W-1:0] den_mem [FILTER_ORDER];
	logic signed [Z_W-1:0]    dl_mem  [DL_N];

	// control
	state_t               state_q, state_d;
	logic [TAP_W-1:0]     t_q;
	logic [CLR_W-1:0]     clr_q;
	logic [GAIN_W-1:0]    gain_q;
	logic                 rsp_valid_q;

	// datapath
	logic signed [SAMPLE_W-1:0] x_q;
	logic [CHANNEL_W-1:0]       ch_q;
	logic [DL_AW-1:0]           base_q;
	logic signed [Z_W-1:0]      y_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [COEF_W-1:0]   num_rd_q;
	logic signed [COEF_W-1:0]   den_rd_q;
	logic signed [Z_W-1:0]      dl_rd_q;
	logic                       z_ok_q;
	logic [CHANNEL_W-1:0]       rsp_ch_q;
	logic signed [SAMPLE_W-1:0] rsp_sample_q;
	logic                       rsp_sat_q;

	logic                       accept, start, t_zero, t_last, clr_done, out_free, g3_fire;
	logic                       fetch_adv, tap_inc;
	logic [TAP_W-1:0]           f_idx, f_dec;
	logic [NUM_AW-1:0]          num_ra;
	logic [DEN_AW-1:0]          den_ra;
	logic [DL_AW-1:0]           dl_ra, dl_wa;
	logic                       clr_num_we, clr_den_we, num_we, den_we, dl_we;
	logic signed [Z_W-1:0]      dl_wd;
	logic signed [COEF_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]  mul_b, x_ext, ylo_ext, yhi_ext;
	logic signed [PROD_W-1:0]   mul_p, p_r5, p_r20, r5, r20;
	logic signed [ACC_W-1:0]    r5_ext, r20_ext, z_ext, prod_ext, alo_sum;
	logic signed [GACC_W-1:0]   g_sum, g_out;
	logic [GACC_W-SAMPLE_W:0]   g_hi;
	logic                       g_sat;
	logic signed [SAMPLE_W-1:0] g_val;

	assign accept   = req.valid && req.ready;
	assign start    = accept && (req.req_type == REQ_SAMPLE) && (32'(req.channel) < CHANNELS);
	assign t_zero   = (t_q == '0);
	assign t_last   = (t_q == TAP_W'(FILTER_ORDER));
	assign clr_done = (clr_q == CLR_W'(CLR_N - 1));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign g3_fire  = (state_q == ST_G3) && out_free;
	assign tap_inc  = ((state_q == ST_ALO) && t_zero) || ((state_q == ST_WB) && !t_last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_BX;
			ST_BX:    state_d = ST_ALO;
			ST_ALO:   state_d = t_zero ? ST_BX : ST_AHI;
			ST_AHI:   state_d = ST_WB;
			ST_WB:    state_d = t_last ? ST_G1 : ST_BX;
			ST_G1:    state_d = ST_G2;
			ST_G2:    state_d = ST_G3;
			ST_G3:    if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	assign x_ext   = $signed({{(MUL_B_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q});
	assign ylo_ext = $signed({1'b0, y_q[YLO_W-1:0]});
	assign yhi_ext = $signed({y_q[Z_W-1], y_q[Z_W-1:YLO_W]});

	// state decode: multiplier operands and fetch pointer
	always_comb begin
		mul_a     = den_rd_q;
		mul_b     = ylo_ext;
		fetch_adv = 1'b0;
		unique case (state_q)
			ST_BX: begin
				mul_a = num_rd_q;
				mul_b = x_ext;
			end
			ST_ALO: fetch_adv = t_zero;
			ST_AHI: begin
				mul_b     = yhi_ext;
				fetch_adv = 1'b1;
			end
			ST_WB: fetch_adv = 1'b1;
			ST_G1: mul_a = $signed({{(COEF_W-GAIN_W){1'b0}}, gain_q});
			// G3 repeats the high gain product so a stalled result keeps its value
			ST_G2, ST_G3: begin
				mul_a = $signed({{(COEF_W-GAIN_W){1'b0}}, gain_q});
				mul_b = yhi_ext;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// read pointers, clamped where the fetch runs past the end
	assign f_idx  = fetch_adv ? t_q + TAP_W'(1) : t_q;
	assign f_dec  = f_idx - TAP_W'(1);
	assign num_ra = (f_idx <= TAP_W'(FILTER_ORDER)) ? f_idx[NUM_AW-1:0] : NUM_AW'(FILTER_ORDER);
	assign den_ra = ((f_idx != '0) && (f_idx <= TAP_W'(FILTER_ORDER))) ?
		f_dec[DEN_AW-1:0] : '0;
	assign dl_ra  = (f_idx < TAP_W'(FILTER_ORDER)) ? base_q + DL_AW'(f_idx) : base_q;
	assign dl_wa  = base_q + DL_AW'(t_q - TAP_W'(1));

	// rounding of products back to Q.30
	assign p_r5     = prod_q + RND5;
	assign r5       = p_r5 >>> 5;
	assign p_r20    = prod_q + RND20;
	assign r20      = p_r20 >>> 20;
	assign r5_ext   = $signed({{(ACC_W-PROD_W){r5[PROD_W-1]}}, r5});
	assign r20_ext  = $signed({{(ACC_W-PROD_W){r20[PROD_W-1]}}, r20});
	assign prod_ext = $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
	assign z_ext    = z_ok_q ? $signed({{(ACC_W-Z_W){dl_rd_q[Z_W-1]}}, dl_rd_q}) : '0;
	assign alo_sum  = r5_ext + z_ext;

	// gain: y*g = (yhi*g << 20) + ylo*g, rounded to Q.15
	assign g_sum = $signed({prod_q[GACC_W-YLO_W-1:0], {YLO_W{1'b0}}})
		+ $signed({{(GACC_W-ACC_W){acc_q[ACC_W-1]}}, acc_q}) + RND27;
	assign g_out = g_sum >>> 27;
	assign g_hi  = g_out[GACC_W-1:SAMPLE_W-1];
	assign g_sat = !((&g_hi) || (~|g_hi));
	assign g_val = g_sat ? (g_out[GACC_W-1] ? OUT_MIN : OUT_MAX) : g_out[SAMPLE_W-1:0];

	// memory write controls
	assign clr_num_we = (state_q == ST_CLEAR) && (32'(clr_q) < NUM_N);
	assign clr_den_we = (state_q == ST_CLEAR) && (32'(clr_q) < FILTER_ORDER);
	assign num_we     = accept && (req.req_type == REQ_NUM) &&
		(32'(req.coef_index) <= FILTER_ORDER);
	assign den_we     = accept && (req.req_type == REQ_DEN) && (req.coef_index != '0) &&
		(32'(req.coef_index) <= FILTER_ORDER);
	assign dl_we      = (state_q == ST_CLEAR) || (state_q == ST_WB);
	assign dl_wd      = (state_q == ST_CLEAR) ? '0 : sat_z(acc_q - prod_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			t_q         <= '0;
			clr_q       <= '0;
			gain_q      <= GAIN_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && !clr_done)
				clr_q <= clr_q + CLR_W'(1);
			if (start)
				t_q <= '0;
			else if (tap_inc)
				t_q <= t_q + TAP_W'(1);
			if (cfg_wr_en)
				gain_q <= cfg_wr_data;
			if (g3_fire)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= req.sample_in;
			ch_q   <= req.channel;
			base_q <= DL_AW'(32'(req.channel) * FILTER_ORDER);
		end
		prod_q <= mul_p;
		z_ok_q <= (f_idx < TAP_W'(FILTER_ORDER));
		unique case (state_q)
			ST_ALO: begin
				if (t_zero)
					y_q <= sat_z(alo_sum);
				acc_q <= alo_sum;
			end
			ST_AHI: acc_q <= acc_q - r20_ext;
			ST_G2:  acc_q <= prod_ext;
			default: ;
		endcase
		if (g3_fire) begin
			rsp_ch_q     <= ch_q;
			rsp_sample_q <= g_val;
			rsp_sat_q    <= g_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_num_we)
			num_mem[clr_q[NUM_AW-1:0]] <= (clr_q == '0) ? COEF_ONE : '0;
		else if (num_we)
			num_mem[NUM_AW'(req.coef_index)] <= req.coef_value;
		num_rd_q <= num_mem[num_ra];
	end

	always_ff @(posedge clk) begin
		if (clr_den_we)
			den_mem[clr_q[DEN_AW-1:0]] <= '0;
		else if (den_we)
			den_mem[DEN_AW'(req.coef_index - COEF_IDX_W'(1))] <= req.coef_value;
		den_rd_q <= den_mem[den_ra];
	end

	always_ff @(posedge clk) begin
		if (dl_we)
			dl_mem[(state_q == ST_CLEAR) ? clr_q[DL_AW-1:0] : dl_wa] <= dl_wd;
		dl_rd_q <= dl_mem[dl_ra];
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.channel_out = rsp_ch_q;
	assign rsp.sample_out  = rsp_sample_q;
	assign rsp.saturated   = rsp_sat_q;

endmodule

// File: src/iir_tdf2_chk.sv
// Port-level checks for the IIR filter, bound to the top level.
module iir_tdf2_chk #(
	parameter int CHANNELS = 4
) (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     req_valid,
	input logic                                     req_ready,
	input logic [iir_tdf2_pkg::REQ_TYPE_W-1:0]      req_type,
	input logic [iir_tdf2_pkg::CHANNEL_W-1:0]       req_channel,
	input logic                                     rsp_valid,
	input logic                                     rsp_ready,
	input logic [iir_tdf2_pkg::CHANNEL_W-1:0]       rsp_channel_out,
	input logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] rsp_sample_out,
	input logic                                     rsp_saturated
);
	import iir_tdf2_pkg::*;

	// a waiting result holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
			&& $stable(rsp_channel_out) && $stable(rsp_saturated))
		else $error("response changed while stalled");

	// a clipped result sits at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_saturated |-> (rsp_sample_out == OUT_MAX || rsp_sample_out == OUT_MIN))
		else $error("saturated flag without rail value");

	// a sample transaction occupies the filter
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_SAMPLE && 32'(req_channel) < CHANNELS
			|=> !req_ready)
		else $error("ready high during sample processing");

	// no result appears straight after a request transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("result too soon after request");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_channel_out) < CHANNELS)
		else $error("result on unconfigured channel");

endmodule

bind iir_filter_transposed_df2 iir_tdf2_chk #(.CHANNELS(CHANNELS)) u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_type        (req.req_type),
	.req_channel     (req.channel),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_channel_out (rsp.channel_out),
	.rsp_sample_out  (rsp.sample_out),
	.rsp_saturated   (rsp.saturated)
);

// File: verif/tb.sv
// Testbench for the transposed direct form II IIR filter: directed table, random phases, scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iir_tdf2_pkg::*;

	localparam int ORDER       = 8;
	localparam int NCH         = 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 60;
	localparam int PHASE_ITEMS = 70;

	localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED = 2'd3;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] kind;
		logic [CHANNEL_W-1:0]  chan;
		logic [SAMPLE_W-1:0]   x;
		logic [COEF_IDX_W-1:0] idx;
		logic [COEF_W-1:0]     val;
	} filter_req_t;

	typedef struct packed {
		logic [CHANNEL_W-1:0] chan;
		logic [SAMPLE_W-1:0]  sample;
		logic                 sat;
	} filtered_t;

	typedef struct packed {
		filter_req_t         rq;
		logic                typed;
		logic [SAMPLE_W-1:0] want;
		logic                want_sat;
	} stim_row_t;

	localparam int N_DIRECTED = 24;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{'{REQ_SAMPLE,   2'd0, 16'h0000, 4'd0,  24'h000000}, 1'b1, 16'h0000, 1'b0},
		'{'{REQ_SAMPLE,   2'd1, 16'h7FFF, 4'd0,  24'h000000}, 1'b1, 16'h7FFF, 1'b0},
		'{'{REQ_SAMPLE,   2'd2, 16'h8000, 4'd0,  24'h000000}, 1'b1, 16'h8000, 1'b0},
		'{'{REQ_SAMPLE,   2'd3, 16'h0001, 4'd0,  24'h000000}, 1'b1, 16'h0001, 1'b0},
		'{'{REQ_SAMPLE,   2'd3, 16'hFFFF, 4'd0,  24'h000000}, 1'b1, 16'hFFFF, 1'b0},
		'{'{REQ_NUM,      2'd0, 16'h0000, 4'd0,  24'h7FFFFF}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_SAMPLE,   2'd0, 16'h7FFF, 4'd0,  24'h000000}, 1'b1, 16'h7FFF, 1'b1},
		'{'{REQ_SAMPLE,   2'd1, 16'h8000, 4'd0,  24'h000000}, 1'b1, 16'h8000, 1'b1},
		'{'{REQ_NUM,      2'd0, 16'h0000, 4'd0,  24'h800000}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_SAMPLE,   2'd2, 16'h8000, 4'd0,  24'h000000}, 1'b1, 16'h7FFF, 1'b1},
		'{'{REQ_NUM,      2'd0, 16'h0000, 4'd0,  24'h100000}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_NUM,      2'd0, 16'h0000, 4'd8,  24'h7FFFFF}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_NUM,      2'd0, 16'h0000, 4'd9,  24'h123456}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_NUM,      2'd0, 16'h0000, 4'd15, 24'h7FFFFF}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_DEN,      2'd0, 16'h0000, 4'd0,  24'h7FFFFF}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_DEN,      2'd0, 16'h0000, 4'd1,  24'h080000}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_DEN,      2'd0, 16'h0000, 4'd8,  24'h800000}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_DEN,      2'd0, 16'h0000, 4'd15, 24'h7FFFFF}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_RESERVED, 2'd3, 16'h7FFF, 4'd5,  24'h7FFFFF}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_SAMPLE,   2'd0, 16'h4000, 4'd0,  24'h000000}, 1'b1, 16'h4000, 1'b0},
		'{'{REQ_SAMPLE,   2'd0, 16'h7FFF, 4'd0,  24'h000000}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_SAMPLE,   2'd0, 16'h8000, 4'd0,  24'h000000}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_SAMPLE,   2'd0, 16'h8000, 4'd0,  24'h000000}, 1'b0, 16'h0000, 1'b0},
		'{'{REQ_SAMPLE,   2'd1, 16'h7FFF, 4'd0,  24'h000000}, 1'b0, 16'h0000, 1'b0}
	};

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [GAIN_W-1:0]   cfg_wr_data;

	iir_req_if req_ch ();
	iir_rsp_if rsp_ch ();

	iir_filter_transposed_df2 #(
		.FILTER_ORDER (ORDER),
		.CHANNELS     (NCH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	// filter state as the block should hold it
	logic signed [COEF_W-1:0] b_coef [ORDER+1];
	logic signed [COEF_W-1:0] a_coef [ORDER];
	logic signed [Z_W-1:0]    z_line [NCH][ORDER];
	logic [GAIN_W-1:0]        gain;

	filtered_t filtered_queue [$];

	bit idling;
	int fails;
	int quiet;
	int n_samples;
	int n_clipped;
	int n_coef_writes;
	int n_outputs;
	int n_gains;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [Z_W-1:0] clamp_z(input longint v);
		if (v > longint'(Z_MAX))
			return Z_MAX;
		if (v < longint'(Z_MIN))
			return Z_MIN;
		return v[Z_W-1:0];
	endfunction

	// one accepted transaction through the filter state; returns 1 when a sample comes out
	function automatic bit tdf2_step(input filter_req_t rq, output filtered_t res);
		longint x, y, t, o;
		res = '0;
		case (rq.kind)
			REQ_NUM: begin
				if (rq.idx <= ORDER)
					b_coef[rq.idx] = $signed(rq.val);
				return 1'b0;
			end
			REQ_DEN: begin
				if (rq.idx >= 1 && rq.idx <= ORDER)
					a_coef[rq.idx - 1] = $signed(rq.val);
				return 1'b0;
			end
			REQ_SAMPLE: ;
			default: return 1'b0;
		endcase
		if (rq.chan >= NCH)
			return 1'b0;

		x = longint'($signed(rq.x));
		y = clamp_z(round_shift(longint'(b_coef[0]) * x, 5) + longint'(z_line[rq.chan][0]));
		for (int j = 0; j < ORDER; j++) begin
			t = round_shift(longint'(b_coef[j + 1]) * x, 5)
				- round_shift(longint'(a_coef[j]) * y, 20);
			if (j + 1 < ORDER)
				t += longint'(z_line[rq.chan][j + 1]);
			z_line[rq.chan][j] = clamp_z(t);
		end

		o = round_shift(y * longint'({48'b0, gain}), 27);
		res.chan = rq.chan;
		res.sat  = 1'b0;
		if (o > 32767) begin
			o = 32767;
			res.sat = 1'b1;
		end else if (o < -32768) begin
			o = -32768;
			res.sat = 1'b1;
		end
		res.sample = o[SAMPLE_W-1:0];
		return 1'b1;
	endfunction

	task automatic send_request(input filter_req_t rq, input logic typed,
			input logic [SAMPLE_W-1:0] want, input logic want_sat);
		filtered_t res;
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= rq.kind;
		req_ch.channel    <= rq.chan;
		req_ch.sample_in  <= rq.x;
		req_ch.coef_index <= rq.idx;
		req_ch.coef_value <= rq.val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (tdf2_step(rq, res)) begin
			n_samples++;
			if (res.sat)
				n_clipped++;
			if (typed) begin
				res.sample = want;
				res.sat    = want_sat;
			end
			filtered_queue.push_back(res);
		end else if (rq.kind == REQ_NUM || rq.kind == REQ_DEN) begin
			n_coef_writes++;
		end
		if (idling && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain_and_settle();
		req_ch.valid <= 1'b0;
		while (filtered_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gain = g;
		n_gains++;
	endtask

	function automatic logic [COEF_W-1:0] pick_coef();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return COEF_W'($urandom_range(0, 2**19) - 2**18);
		if (r < 8)
			return COEF_W'($urandom());
		if (r == 8)
			return $urandom_range(0, 1) ? COEF_ONE : -COEF_ONE;
		return '0;
	endfunction

	task automatic random_phase(input int count);
		filter_req_t rq;
		int done;
		int r;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			rq.chan = CHANNEL_W'($urandom_range(0, NCH - 1));
			rq.x    = SAMPLE_W'($urandom());
			rq.idx  = COEF_IDX_W'($urandom());
			rq.val  = COEF_W'($urandom());
			if (r < 70) begin
				rq.kind = REQ_SAMPLE;
				case ($urandom_range(0, 3))
					0, 1: ;
					2: rq.x = SAMPLE_W'($urandom_range(0, 4095) - 2048);
					default: rq.x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				endcase
				done++;
			end else if (r < 80) begin
				rq.kind = REQ_NUM;
				if ($urandom_range(0, 3) != 0)
					rq.idx = COEF_IDX_W'($urandom_range(0, ORDER));
				rq.val = pick_coef();
				done++;
			end else if (r < 93) begin
				rq.kind = REQ_DEN;
				if ($urandom_range(0, 3) != 0)
					rq.idx = COEF_IDX_W'($urandom_range(1, ORDER));
				rq.val = pick_coef();
				done++;
			end else begin
				rq.kind = REQ_RESERVED;
			end
			send_request(rq, 1'b0, '0, 1'b0);
		end
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_outputs
		filtered_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_outputs++;
			if (filtered_queue.size() == 0) begin
				$error("unexpected output transaction: channel %0d sample %0d",
					rsp_ch.channel_out, rsp_ch.sample_out);
				fails++;
			end else begin
				want = filtered_queue.pop_front();
				if (rsp_ch.channel_out !== want.chan) begin
					$error("channel_out: expected %0d, got %0d", want.chan, rsp_ch.channel_out);
					fails++;
				end
				if (rsp_ch.sample_out !== want.sample) begin
					$error("sample_out: expected %0d, got %0d",
						$signed(want.sample), rsp_ch.sample_out);
					fails++;
				end
				if (rsp_ch.saturated !== want.sat) begin
					$error("saturated: expected %0d, got %0d", want.sat, rsp_ch.saturated);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$error("no transaction for %0d cycles", QUIET_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [GAIN_W-1:0] g;
		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= GAIN_RESET;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_SAMPLE;
		req_ch.channel     <= '0;
		req_ch.sample_in   <= '0;
		req_ch.coef_index  <= '0;
		req_ch.coef_value  <= '0;
		idling             = 1'b1;
		fails              = 0;
		quiet              = 0;
		n_samples          = 0;
		n_clipped          = 0;
		n_coef_writes      = 0;
		n_outputs          = 0;
		n_gains            = 0;
		gain               = GAIN_RESET;
		foreach (b_coef[i])
			b_coef[i] = '0;
		b_coef[0] = COEF_ONE;
		foreach (a_coef[i])
			a_coef[i] = '0;
		foreach (z_line[c, j])
			z_line[c][j] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_request(DIRECTED[i].rq, DIRECTED[i].typed, DIRECTED[i].want,
				DIRECTED[i].want_sat);

		for (int p = 0; p < 5; p++) begin
			drain_and_settle();
			case (p)
				0: g = 16'hFFFF;
				1: g = 16'h0000;
				2: g = 16'h0001;
				3: g = GAIN_W'($urandom());
				default: g = GAIN_RESET;
			endcase
			write_gain(g);
			if (p == 4)
				idling = 1'b0;
			random_phase(PHASE_ITEMS);
		end

		drain_and_settle();
		$display("%0d samples filtered (%0d clipped), %0d coefficient writes, %0d gain settings",
			n_samples, n_clipped, n_coef_writes, n_gains + 1);
		$display("%0d output transactions checked, %0d mismatches", n_outputs, fails);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: iir_filter_transposed_df2.f
src/iir_tdf2_pkg.sv
src/iir_req_if.sv
src/iir_rsp_if.sv
src/iir_filter_transposed_df2.sv
src/iir_tdf2_chk.sv
verif/tb.sv
